// ----- hw/rtl/lolm_pkg.sv -----
// Shared types and constants for the linked order list mover.
// Holds the transfer payload structs, request and status codes, and the
// command and status groups that join the controller and the datapath.
`timescale 1ns / 1ps

package lolm_pkg;

    localparam int NODE_W   = 11;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 2;

    localparam logic [NODE_W-1:0] COUNT_RESET = 11'd1024;

    typedef enum logic [REQ_W-1:0] {
        REQ_BEFORE = 2'd0,
        REQ_AFTER  = 2'd1,
        REQ_CHECK  = 2'd2,
        REQ_INIT   = 2'd3
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_MOVED    = 2'd0,
        ST_IN_PLACE = 2'd1,
        ST_BAD      = 2'd2,
        ST_DONE     = 2'd3
    } status_t;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [NODE_W-1:0] node_x;
        logic [NODE_W-1:0] node_y;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                in_order;
    } out_item_t;

    // Datapath operations issued by the controller, one per cycle.
    typedef enum logic [3:0] {
        OP_NONE    = 4'd0,
        OP_LOAD    = 4'd1,
        OP_RD_Y    = 4'd2,
        OP_RD_X    = 4'd3,
        OP_UNLINK  = 4'd4,
        OP_RD_PY   = 4'd5,
        OP_RD_NT   = 4'd6,
        OP_LINK_X  = 4'd7,
        OP_LINK_T  = 4'd8,
        OP_INIT_WR = 4'd9,
        OP_CHK_RD  = 4'd10,
        OP_OUT     = 4'd11
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        status_t status;
    } cmd_t;

    typedef struct packed {
        req_t req;
        logic bad;
        logic same;
        logic in_place;
        logic init_last;
        logic chk_last;
        logic out_full;
    } sts_t;

endpackage

// ----- hw/rtl/lolm_dp.sv -----
// Datapath of the linked order list mover: request registers, the two link
// tables, the init and check counter, and the result register.
// Depends on lolm_pkg; driven by commands from lolm_ctrl.
`timescale 1ns / 1ps

module lolm_dp
    import lolm_pkg::*;
#(
    parameter int MAX_NODES = 1024
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [NODE_W-1:0] cfg_data,
    input  in_item_t          in_data,
    input  logic              out_stall,
    output logic              out_valid,
    output out_item_t         out_data,
    input  cmd_t              cmd,
    output sts_t              sts
);

    localparam int DEPTH = MAX_NODES + 2;
    localparam int IDX_W = $clog2(DEPTH);
    localparam logic [IDX_W-1:0] IDX_ZERO = '0;
    localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);

    logic [NODE_W-1:0] count_reg;
    req_t              req_reg;
    logic [IDX_W-1:0]  x_reg;
    logic [IDX_W-1:0]  y_reg;
    logic [IDX_W-1:0]  n_reg;
    logic              bad_reg;
    logic              same_reg;
    logic [IDX_W-1:0]  cnt_reg;
    logic              ok_reg;
    logic              chk_pend_reg;
    logic [IDX_W-1:0]  prd_reg;
    logic [IDX_W-1:0]  nrd_reg;
    logic [IDX_W-1:0]  t_reg;
    logic [IDX_W-1:0]  after_reg;
    logic              out_valid_reg;
    out_item_t         out_data_reg;

    logic [IDX_W-1:0]  prev_mem [0:DEPTH-1];
    logic [IDX_W-1:0]  next_mem [0:DEPTH-1];

    logic [31:0]       count_wide;
    logic [31:0]       n_wide;
    logic [31:0]       x_wide;
    logic [31:0]       y_wide;
    logic [IDX_W-1:0]  n_plus_one;
    logic [IDX_W-1:0]  t_sel;

    logic              p_re;
    logic [IDX_W-1:0]  p_ra;
    logic              p_we;
    logic [IDX_W-1:0]  p_wa;
    logic [IDX_W-1:0]  p_wd;
    logic              n_re;
    logic [IDX_W-1:0]  n_ra;
    logic              n_we;
    logic [IDX_W-1:0]  n_wa;
    logic [IDX_W-1:0]  n_wd;

    // Effective node count, saturated into 1..MAX_NODES.
    always_comb
    begin
        count_wide = 32'(count_reg);
        x_wide     = 32'(in_data.node_x);
        y_wide     = 32'(in_data.node_y);
        if (count_wide == 32'd0)
        begin
            n_wide = 32'd1;
        end
        else if (count_wide > 32'(MAX_NODES))
        begin
            n_wide = 32'(MAX_NODES);
        end
        else
        begin
            n_wide = count_wide;
        end
    end

    assign n_plus_one = n_reg + IDX_ONE;
    // Node that X is linked after: the predecessor of Y for a move before Y.
    assign t_sel      = (req_reg == REQ_BEFORE) ? prd_reg : y_reg;

    always_comb
    begin
        p_re = 1'b0;
        p_ra = y_reg;
        p_we = 1'b0;
        p_wa = cnt_reg;
        p_wd = x_reg;
        n_re = 1'b0;
        n_ra = y_reg;
        n_we = 1'b0;
        n_wa = cnt_reg;
        n_wd = x_reg;
        unique case (cmd.op)
            OP_RD_Y:
            begin
                p_re = 1'b1;
                n_re = 1'b1;
            end
            OP_RD_X:
            begin
                p_re = 1'b1;
                p_ra = x_reg;
                n_re = 1'b1;
                n_ra = x_reg;
            end
            OP_UNLINK:
            begin
                n_we = 1'b1;
                n_wa = prd_reg;
                n_wd = nrd_reg;
                p_we = 1'b1;
                p_wa = nrd_reg;
                p_wd = prd_reg;
            end
            OP_RD_PY:
            begin
                p_re = 1'b1;
            end
            OP_RD_NT:
            begin
                n_re = 1'b1;
                n_ra = t_sel;
            end
            OP_LINK_X:
            begin
                p_we = 1'b1;
                p_wa = x_reg;
                p_wd = t_reg;
                n_we = 1'b1;
                n_wa = x_reg;
                n_wd = nrd_reg;
            end
            OP_LINK_T:
            begin
                n_we = 1'b1;
                n_wa = t_reg;
                p_we = 1'b1;
                p_wa = after_reg;
            end
            OP_INIT_WR:
            begin
                p_we = 1'b1;
                p_wd = (cnt_reg == IDX_ZERO) ? IDX_ZERO : cnt_reg - IDX_ONE;
                n_we = 1'b1;
                n_wd = (cnt_reg == n_plus_one) ? n_plus_one : cnt_reg + IDX_ONE;
            end
            OP_CHK_RD:
            begin
                n_re = 1'b1;
                n_ra = cnt_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (p_we)
        begin
            prev_mem[p_wa] <= p_wd;
        end
        if (p_re)
        begin
            prd_reg <= prev_mem[p_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (n_we)
        begin
            next_mem[n_wa] <= n_wd;
        end
        if (n_re)
        begin
            nrd_reg <= next_mem[n_ra];
        end
    end

    // Request fields, validation flags and move temporaries.
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
        begin
            req_reg  <= req_t'(in_data.req_type);
            x_reg    <= IDX_W'(in_data.node_x);
            y_reg    <= IDX_W'(in_data.node_y);
            n_reg    <= IDX_W'(n_wide);
            bad_reg  <= (x_wide == 32'd0) || (x_wide > n_wide) ||
                        (y_wide == 32'd0) || (y_wide > n_wide);
            same_reg <= (in_data.node_x == in_data.node_y);
        end
        if (cmd.op == OP_RD_NT)
        begin
            t_reg <= t_sel;
        end
        if (cmd.op == OP_LINK_X)
        begin
            after_reg <= nrd_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= COUNT_RESET;
            cnt_reg       <= '0;
            ok_reg        <= 1'b1;
            chk_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                count_reg <= cfg_data;
            end
            chk_pend_reg <= (cmd.op == OP_CHK_RD);
            if (cmd.op == OP_LOAD)
            begin
                cnt_reg <= '0;
                ok_reg  <= 1'b1;
            end
            else
            begin
                if (cmd.op == OP_INIT_WR || cmd.op == OP_CHK_RD)
                begin
                    cnt_reg <= cnt_reg + IDX_ONE;
                end
                // The entry read by the previous check command must point at the next node.
                if (chk_pend_reg && (nrd_reg != cnt_reg))
                begin
                    ok_reg <= 1'b0;
                end
            end
            if (cmd.op == OP_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_OUT)
        begin
            out_data_reg.status   <= cmd.status;
            out_data_reg.in_order <= (req_reg == REQ_CHECK) && ok_reg;
        end
    end

    always_comb
    begin
        sts.req       = req_reg;
        sts.bad       = bad_reg;
        sts.same      = same_reg;
        sts.in_place  = (req_reg == REQ_BEFORE) ? (prd_reg == x_reg) : (nrd_reg == x_reg);
        sts.init_last = (cnt_reg == n_plus_one);
        sts.chk_last  = (cnt_reg == n_reg);
        sts.out_full  = out_valid_reg && out_stall;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- hw/rtl/lolm_ctrl.sv -----
// Controller of the linked order list mover: sequences the link table
// accesses of each request and issues one datapath command per cycle.
// Depends on lolm_pkg.
`timescale 1ns / 1ps

module lolm_ctrl
    import lolm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_DECODE  = 13'b0000000000010,
        S_RD_Y    = 13'b0000000000100,
        S_TEST    = 13'b0000000001000,
        S_UNLINK  = 13'b0000000010000,
        S_RD_PY   = 13'b0000000100000,
        S_RD_NT   = 13'b0000001000000,
        S_LINK_X  = 13'b0000010000000,
        S_LINK_T  = 13'b0000100000000,
        S_INIT    = 13'b0001000000000,
        S_CHECK   = 13'b0010000000000,
        S_CHK_END = 13'b0100000000000,
        S_DONE    = 13'b1000000000000
    } state_t;

    state_t  state_reg;
    state_t  state_next;
    status_t status_reg;
    status_t status_next;

    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        cmd.op      = OP_NONE;
        cmd.status  = status_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                priority if (sts.req == REQ_INIT)
                begin
                    status_next = ST_DONE;
                    state_next  = S_INIT;
                end
                else if (sts.req == REQ_CHECK)
                begin
                    status_next = ST_DONE;
                    state_next  = S_CHECK;
                end
                else if (sts.bad)
                begin
                    status_next = ST_BAD;
                    state_next  = S_DONE;
                end
                else if (sts.same)
                begin
                    status_next = ST_IN_PLACE;
                    state_next  = S_DONE;
                end
                else
                begin
                    status_next = ST_MOVED;
                    state_next  = S_RD_Y;
                end
            end
            S_RD_Y:
            begin
                cmd.op     = OP_RD_Y;
                state_next = S_TEST;
            end
            S_TEST:
            begin
                if (sts.in_place)
                begin
                    status_next = ST_IN_PLACE;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.op     = OP_RD_X;
                    state_next = S_UNLINK;
                end
            end
            S_UNLINK:
            begin
                cmd.op     = OP_UNLINK;
                state_next = S_RD_PY;
            end
            S_RD_PY:
            begin
                cmd.op     = OP_RD_PY;
                state_next = S_RD_NT;
            end
            S_RD_NT:
            begin
                cmd.op     = OP_RD_NT;
                state_next = S_LINK_X;
            end
            S_LINK_X:
            begin
                cmd.op     = OP_LINK_X;
                state_next = S_LINK_T;
            end
            S_LINK_T:
            begin
                cmd.op     = OP_LINK_T;
                state_next = S_DONE;
            end
            S_INIT:
            begin
                cmd.op = OP_INIT_WR;
                if (sts.init_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_CHECK:
            begin
                cmd.op = OP_CHK_RD;
                if (sts.chk_last)
                begin
                    state_next = S_CHK_END;
                end
            end
            S_CHK_END:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!sts.out_full)
                begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            status_reg <= ST_DONE;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

// ----- hw/rtl/linked_order_list_mover.sv -----
// Top level of the linked order list mover.
// Instantiates lolm_ctrl and lolm_dp; uses lolm_pkg for payload types.
`timescale 1ns / 1ps

// The block keeps an order of nodes 1..n as a doubly linked list in two
// link tables (previous and next), with a head sentinel 0 and a tail
// sentinel n+1. Each request transfer produces exactly one result
// transfer. An init request must be issued before any move or check, since
// the tables are not cleared at reset. The block works on one request at a
// time; each command reads or writes each table at most once. A rejected or
// same-node move needs no table access, a move found already in place reads
// the entries of Y, a full move reads Y and X, unlinks X, reads the anchor
// and its next node, then links X in, and init and check go one table entry
// per cycle. A finished result waits in an output register, so the next
// request is taken while it is still stalled; only a second finished result
// waits for the first to be taken. The user must write the node count through
// cfg_we and cfg_data only while the block is idle; the block does not enforce
// this. The count is saturated into 1..MAX_NODES when a request is accepted.

module linked_order_list_mover
    import lolm_pkg::*;
#(
    parameter int MAX_NODES = 1024
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [NODE_W-1:0] cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  in_item_t          in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output out_item_t         out_data
);

    cmd_t cmd;
    sts_t sts;

    // Sequencer: one command per cycle to the datapath.
    lolm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Link tables, request registers and the result register.
    lolm_dp #(
        .MAX_NODES (MAX_NODES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// ----- tb/linked_order_list_mover_tb.sv -----
// Self-checking testbench for linked_order_list_mover.
// Depends on lolm_pkg for payload types and codes, and on the RTL top level;
// a directed table is followed by phases of random requests at many node counts.
`timescale 1ns / 1ps

module linked_order_list_mover_tb;
    import lolm_pkg::*;

    localparam int MAX_NODES     = 1024;
    localparam int TBL_DEPTH     = MAX_NODES + 2;
    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 5;
    localparam int RANDOM_ITEMS  = 1830;
    localparam int SETTLE_CYCLES = 8;
    localparam int END_CYCLES    = 40;
    localparam int LONG_HOLD     = 300;
    localparam int CYCLE_LIMIT   = 15000000;
    localparam int DIRECTED_ROWS = 22;
    localparam int EDGE_PHASES   = 6;

    // One row of the directed table. When has_typed is set, the expected
    // result is the one written in the row; otherwise the predictor supplies it.
    typedef struct packed {
        req_t              req;
        logic [NODE_W-1:0] node_x;
        logic [NODE_W-1:0] node_y;
        logic              has_typed;
        status_t           status;
        logic              in_order;
    } stim_row_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [NODE_W-1:0] cfg_data  = COUNT_RESET;
    logic              in_valid  = 1'b0;
    in_item_t          in_data   = '0;
    logic              out_stall = 1'b0;
    logic              in_stall;
    logic              out_valid;
    out_item_t         out_data;

    // Predictor state: its own copy of the node count and both link tables.
    logic [NODE_W-1:0] count_reg = COUNT_RESET;
    logic [NODE_W-1:0] prev_tbl [TBL_DEPTH];
    logic [NODE_W-1:0] next_tbl [TBL_DEPTH];

    // Results still owed by the block, oldest first.
    out_item_t pending_results [$];

    int unsigned errors      = 0;
    int unsigned cycles      = 0;
    int unsigned burst_left  = 0;
    int unsigned sink_left   = 0;
    int unsigned hold_asked  = 0;
    int unsigned hold_taken  = 0;

    // The first row is an init at the reset count of 1024, so every entry of
    // both tables is written before anything reads them. Nothing else in the
    // run can reach an entry that was never written.
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{REQ_INIT,   11'd0,    11'd0,    1'b1, ST_DONE,     1'b0},
        '{REQ_CHECK,  11'd0,    11'd0,    1'b1, ST_DONE,     1'b1},
        '{REQ_BEFORE, 11'd0,    11'd1,    1'b1, ST_BAD,      1'b0},
        '{REQ_AFTER,  11'd1,    11'd0,    1'b1, ST_BAD,      1'b0},
        '{REQ_BEFORE, 11'd1025, 11'd1,    1'b1, ST_BAD,      1'b0},
        '{REQ_AFTER,  11'd1,    11'd1025, 1'b1, ST_BAD,      1'b0},
        '{REQ_BEFORE, 11'd2047, 11'd2047, 1'b1, ST_BAD,      1'b0},
        '{REQ_CHECK,  11'd2047, 11'd2047, 1'b1, ST_DONE,     1'b1},
        '{REQ_BEFORE, 11'd7,    11'd7,    1'b1, ST_IN_PLACE, 1'b0},
        '{REQ_AFTER,  11'd1024, 11'd1024, 1'b1, ST_IN_PLACE, 1'b0},
        '{REQ_BEFORE, 11'd1,    11'd2,    1'b0, ST_MOVED,    1'b0},
        '{REQ_AFTER,  11'd2,    11'd1,    1'b0, ST_MOVED,    1'b0},
        '{REQ_BEFORE, 11'd1024, 11'd1,    1'b0, ST_MOVED,    1'b0},
        '{REQ_CHECK,  11'd0,    11'd0,    1'b0, ST_MOVED,    1'b0},
        '{REQ_AFTER,  11'd1,    11'd1024, 1'b0, ST_MOVED,    1'b0},
        '{REQ_AFTER,  11'd1024, 11'd1023, 1'b0, ST_MOVED,    1'b0},
        '{REQ_CHECK,  11'd0,    11'd0,    1'b0, ST_MOVED,    1'b0},
        '{REQ_AFTER,  11'd1,    11'd1024, 1'b0, ST_MOVED,    1'b0},
        '{REQ_BEFORE, 11'd1,    11'd2,    1'b0, ST_MOVED,    1'b0},
        '{REQ_INIT,   11'd1365, 11'd682,  1'b1, ST_DONE,     1'b0},
        '{REQ_BEFORE, 11'd1,    11'd1024, 1'b0, ST_MOVED,    1'b0},
        '{REQ_CHECK,  11'd0,    11'd0,    1'b0, ST_MOVED,    1'b0}
    };

    // Node counts visited first so that every extreme of the register is
    // exercised: zero acts as one, and anything above 1024 saturates.
    logic [NODE_W-1:0] edge_counts [EDGE_PHASES] = '{
        11'd0, 11'd2047, 11'd1, 11'd2, 11'd1025, 11'd1024
    };

    linked_order_list_mover #(
        .MAX_NODES (MAX_NODES)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Run limit: far beyond the slowest correct run of this stimulus.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_results.size());
            $display("linked_order_list_mover: mismatch");
            $finish;
        end
    end

    task automatic report_mismatch(input string detail);
        $display("[%0t] error: %s", $time, detail);
        errors++;
    endtask

    // Table indexes beyond the tables fold onto the head sentinel entry.
    function automatic logic [NODE_W-1:0] table_slot(input logic [NODE_W-1:0] i);
        return (i < TBL_DEPTH) ? i : '0;
    endfunction

    // The count as the block uses it, saturated into 1..MAX_NODES.
    function automatic logic [NODE_W-1:0] active_nodes();
        if (count_reg == '0)
            return 11'd1;
        if (count_reg > MAX_NODES)
            return NODE_W'(MAX_NODES);
        return count_reg;
    endfunction

    // Applies one request to the predictor's tables and returns the result
    // that the block owes for it.
    function automatic out_item_t model_request(input in_item_t item);
        logic [NODE_W-1:0] n;
        logic [NODE_W-1:0] x;
        logic [NODE_W-1:0] y;
        logic [NODE_W-1:0] i;
        logic [NODE_W-1:0] cur;
        logic [NODE_W-1:0] left;
        logic [NODE_W-1:0] right;
        logic [NODE_W-1:0] anchor;
        logic [NODE_W-1:0] after;
        logic              ok;
        req_t              req;
        out_item_t         res;

        n   = active_nodes();
        x   = item.node_x;
        y   = item.node_y;
        req = req_t'(item.req_type);
        res.status   = ST_DONE;
        res.in_order = 1'b0;

        if (req == REQ_INIT)
        begin
            prev_tbl[0] = '0;
            next_tbl[0] = 11'd1;
            for (i = 11'd1; i <= n; i++)
            begin
                prev_tbl[i] = i - 11'd1;
                next_tbl[i] = i + 11'd1;
            end
            prev_tbl[n + 11'd1] = n;
            next_tbl[n + 11'd1] = n + 11'd1;
        end
        else if (req == REQ_CHECK)
        begin
            // Walk at most n links from the head, then expect the tail.
            ok  = 1'b1;
            cur = '0;
            for (i = 11'd1; i <= n && ok; i++)
            begin
                cur = next_tbl[table_slot(cur)];
                if (cur != i)
                    ok = 1'b0;
            end
            if (ok && next_tbl[table_slot(cur)] != n + 11'd1)
                ok = 1'b0;
            res.in_order = ok;
        end
        else if (x < 11'd1 || x > n || y < 11'd1 || y > n)
            res.status = ST_BAD;
        else if (x == y)
            res.status = ST_IN_PLACE;
        else if (req == REQ_BEFORE && prev_tbl[table_slot(y)] == x)
            res.status = ST_IN_PLACE;
        else if (req == REQ_AFTER && next_tbl[table_slot(y)] == x)
            res.status = ST_IN_PLACE;
        else
        begin
            left  = prev_tbl[table_slot(x)];
            right = next_tbl[table_slot(x)];
            next_tbl[table_slot(left)]  = right;
            prev_tbl[table_slot(right)] = left;
            // The anchor is read only after X has been taken out.
            anchor = (req == REQ_BEFORE) ? prev_tbl[table_slot(y)] : y;
            after  = next_tbl[table_slot(anchor)];
            prev_tbl[table_slot(x)]      = anchor;
            next_tbl[table_slot(x)]      = after;
            next_tbl[table_slot(anchor)] = x;
            prev_tbl[table_slot(after)]  = x;
            res.status = ST_MOVED;
        end
        return res;
    endfunction

    // Sender gap: mostly none or short, a few long, and bursts with no gap.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (burst_left != 0)
        begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Random request at the current count. Most moves name two valid nodes,
    // some aim at the place where X already sits, and a few are malformed.
    function automatic in_item_t random_request();
        logic [NODE_W-1:0] n;
        int unsigned       r;
        in_item_t          item;

        n = active_nodes();
        r = $urandom_range(0, 99);
        item.node_x   = NODE_W'($urandom_range(1, n));
        item.node_y   = NODE_W'($urandom_range(1, n));
        item.req_type = $urandom_range(0, 1) ? REQ_AFTER : REQ_BEFORE;
        if (r < 6)
        begin
            item.req_type = REQ_INIT;
            item.node_x   = NODE_W'($urandom_range(0, 2047));
            item.node_y   = NODE_W'($urandom_range(0, 2047));
        end
        else if (r < 16)
        begin
            item.req_type = REQ_CHECK;
            item.node_x   = NODE_W'($urandom_range(0, 2047));
            item.node_y   = NODE_W'($urandom_range(0, 2047));
        end
        else if (r < 23)
        begin
            case ($urandom_range(0, 4))
                0: item.node_x = '0;
                1: item.node_y = '0;
                2: item.node_x = NODE_W'($urandom_range(n + 1, 2047));
                3: item.node_y = NODE_W'($urandom_range(n + 1, 2047));
                default:
                begin
                    item.node_x = NODE_W'($urandom_range(0, 2047));
                    item.node_y = NODE_W'($urandom_range(n + 1, 2047));
                end
            endcase
        end
        else if (r < 31)
        begin
            // Point X at the node already in front of or behind Y.
            if (item.req_type == REQ_BEFORE)
                item.node_x = prev_tbl[item.node_y];
            else
                item.node_x = next_tbl[item.node_y];
        end
        else if (r < 34)
            item.node_x = item.node_y;
        return item;
    endfunction

    // Offers one request and holds it until the block takes it. Acceptance
    // is read at the falling edge, where stall is settled for the next rising
    // edge; the expectation is queued before that edge. Valid is left high so
    // that the next request can follow with no gap.
    task automatic send_request(input in_item_t item, input int unsigned gap,
                                input logic has_typed, input out_item_t typed);
        logic      taken;
        out_item_t predicted;

        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            if (!in_stall)
            begin
                taken     = 1'b1;
                predicted = model_request(item);
                pending_results.push_back(has_typed ? typed : predicted);
            end
            @(posedge clk);
        end
    endtask

    // Waits until every owed result has arrived, then lets the block settle.
    task automatic wait_until_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register writes happen only with the block idle.
    task automatic write_node_count(input logic [NODE_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        count_reg = value;
    endtask

    // Result side: stall in runs of random length. A request from the
    // stimulus process turns the next run into one long hold-off, counted here.
    always @(posedge clk)
    begin : result_sink
        int unsigned r;
        if (sink_left != 0)
            sink_left--;
        else if (hold_taken != hold_asked)
        begin
            hold_taken = hold_asked;
            out_stall <= 1'b1;
            sink_left = LONG_HOLD - 1;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
            begin
                out_stall <= 1'b0;
                sink_left = $urandom_range(0, 7);
            end
            else if (r < 66)
            begin
                out_stall <= 1'b0;
                sink_left = $urandom_range(40, 150);
            end
            else if (r < 94)
            begin
                out_stall <= 1'b1;
                sink_left = $urandom_range(0, 2);
            end
            else
            begin
                out_stall <= 1'b1;
                sink_left = $urandom_range(10, 50);
            end
        end
    end

    // Every result transfer is checked against the oldest expectation.
    always @(negedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("result status %0d with no request pending",
                                          out_data.status));
            else
            begin
                want = pending_results.pop_front();
                if (out_data.status !== want.status)
                    report_mismatch($sformatf("status got %0d, expected %0d",
                                              out_data.status, want.status));
                if (out_data.in_order !== want.in_order)
                    report_mismatch($sformatf("in_order got %0d, expected %0d",
                                              out_data.in_order, want.in_order));
            end
        end
    end

    initial
    begin : stimulus
        int unsigned       row;
        int unsigned       sent;
        int unsigned       phase;
        int unsigned       phase_len;
        int unsigned       k;
        int unsigned       r;
        logic [NODE_W-1:0] count_value;
        in_item_t          item;
        out_item_t         typed;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table at the reset count of 1024.
        for (row = 0; row < DIRECTED_ROWS; row++)
        begin
            item.req_type  = directed_rows[row].req;
            item.node_x    = directed_rows[row].node_x;
            item.node_y    = directed_rows[row].node_y;
            typed.status   = directed_rows[row].status;
            typed.in_order = directed_rows[row].in_order;
            send_request(item, pick_gap(), directed_rows[row].has_typed, typed);
        end

        // Random phases, each at its own node count. Most phases start with
        // an init; the rest keep the links left by an earlier count.
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            wait_until_drained();
            if (phase < EDGE_PHASES)
                count_value = edge_counts[phase];
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 6)
                    count_value = '0;
                else if (r < 12)
                    count_value = 11'd1;
                else if (r < 16)
                    count_value = 11'd2;
                else if (r < 19)
                    count_value = 11'd1024;
                else if (r < 21)
                    count_value = NODE_W'($urandom_range(1025, 2047));
                else if (r < 75)
                    count_value = NODE_W'($urandom_range(3, 12));
                else if (r < 95)
                    count_value = NODE_W'($urandom_range(13, 200));
                else
                    count_value = NODE_W'($urandom_range(201, 1023));
            end
            write_node_count(count_value);

            // Once, at a small count, the result side holds off for a long
            // stretch while requests keep coming back to back, so the block
            // fills up and stalls its input.
            if (phase == 3)
            begin
                hold_asked++;
                burst_left = 40;
            end

            if ($urandom_range(0, 99) < 80)
            begin
                item.req_type = REQ_INIT;
                item.node_x   = NODE_W'($urandom_range(0, 2047));
                item.node_y   = NODE_W'($urandom_range(0, 2047));
                send_request(item, pick_gap(), 1'b0, typed);
                sent++;
            end

            phase_len = $urandom_range(30, 90);
            for (k = 0; k < phase_len && sent < RANDOM_ITEMS; k++)
            begin
                // Now and then the sender waits for every owed result first.
                if ($urandom_range(0, 99) < 2)
                    wait_until_drained();
                send_request(random_request(), pick_gap(), 1'b0, typed);
                sent++;
            end
            phase++;
        end

        wait_until_drained();
        repeat (END_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("linked_order_list_mover: match");
        else
            $display("linked_order_list_mover: mismatch");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/lolm_pkg.sv
hw/rtl/lolm_dp.sv
hw/rtl/lolm_ctrl.sv
hw/rtl/linked_order_list_mover.sv
tb/linked_order_list_mover_tb.sv
